// ===== hdl/kfkd_pkg.sv =====
// shared types, constants and key tables of the keyboard frame key decoder
package kfkd_pkg;

   localparam logic [7:0] HDR_BYTE   = 8'hAA;
   localparam logic [7:0] LEN_BYTE   = 8'h03;
   localparam logic [7:0] PRESS_CODE = 8'h01;
   localparam logic [7:0] KEY_AA     = 8'd22;
   localparam logic [7:0] KEY_FN     = 8'd33;
   localparam logic [7:0] KEY_SYM    = 8'd34;
   localparam logic [6:0] CODE_NONE  = 7'h00;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_UPPER_Z = 7'h5A;
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;
   localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;
   localparam logic [6:0] CASE_OFFSET  = 7'h20;
   localparam logic [15:0] WINDOW_RESET = 16'd400;

   typedef enum logic [1:0] {
      KIND_KEY = 2'd0,
      KIND_FN  = 2'd1,
      KIND_SYM = 2'd2,
      KIND_AA  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  key_id;
      logic        pressed;
      logic [31:0] now_ms;
   } frame_type;

   function automatic logic [6:0] normal_code(input logic [7:0] id);
      logic [6:0] c;
      case (id)
         8'd0:  c = 7'h31;
         8'd1:  c = 7'h32;
         8'd2:  c = 7'h33;
         8'd3:  c = 7'h34;
         8'd4:  c = 7'h35;
         8'd5:  c = 7'h36;
         8'd6:  c = 7'h37;
         8'd7:  c = 7'h38;
         8'd8:  c = 7'h39;
         8'd9:  c = 7'h30;
         8'd11: c = 7'h71;
         8'd12: c = 7'h77;
         8'd13: c = 7'h65;
         8'd14: c = 7'h72;
         8'd15: c = 7'h74;
         8'd16: c = 7'h79;
         8'd17: c = 7'h75;
         8'd18: c = 7'h69;
         8'd19: c = 7'h6F;
         8'd20: c = 7'h70;
         8'd21: c = 7'h08;
         8'd23: c = 7'h61;
         8'd24: c = 7'h73;
         8'd25: c = 7'h64;
         8'd26: c = 7'h66;
         8'd27: c = 7'h67;
         8'd28: c = 7'h68;
         8'd29: c = 7'h6A;
         8'd30: c = 7'h6B;
         8'd31: c = 7'h6C;
         8'd32: c = 7'h0A;
         8'd35: c = 7'h7A;
         8'd36: c = 7'h78;
         8'd37: c = 7'h63;
         8'd38: c = 7'h76;
         8'd39: c = 7'h62;
         8'd40: c = 7'h6E;
         8'd41: c = 7'h6D;
         8'd42: c = 7'h20;
         default: c = CODE_NONE;
      endcase
      return c;
   endfunction

   // upper case table: letters shifted, everything else as normal
   function automatic logic [6:0] caps_code(input logic [7:0] id);
      logic [6:0] c;
      c = normal_code(id);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         c = c - CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic logic [6:0] sym_code(input logic [7:0] id);
      logic [6:0] c;
      case (id)
         8'd0:  c = 7'h21;
         8'd1:  c = 7'h40;
         8'd2:  c = 7'h23;
         8'd3:  c = 7'h24;
         8'd4:  c = 7'h25;
         8'd5:  c = 7'h5E;
         8'd6:  c = 7'h26;
         8'd7:  c = 7'h2A;
         8'd8:  c = 7'h28;
         8'd9:  c = 7'h29;
         8'd11: c = 7'h7E;
         8'd12: c = 7'h60;
         8'd13: c = 7'h3F;
         8'd14: c = 7'h5C;
         8'd15: c = 7'h2F;
         8'd16: c = 7'h7C;
         8'd17: c = 7'h5F;
         8'd18: c = 7'h2D;
         8'd19: c = 7'h2B;
         8'd20: c = 7'h3D;
         8'd21: c = 7'h08;
         8'd23: c = 7'h7B;
         8'd24: c = 7'h7D;
         8'd25: c = 7'h5E;
         8'd26: c = 7'h5B;
         8'd27: c = 7'h5D;
         8'd28: c = 7'h22;
         8'd29: c = 7'h27;
         8'd30: c = 7'h3B;
         8'd31: c = 7'h3A;
         8'd32: c = 7'h0A;
         8'd35: c = 7'h5A;
         8'd36: c = 7'h58;
         8'd37: c = 7'h43;
         8'd38: c = 7'h3C;
         8'd39: c = 7'h3E;
         8'd40: c = 7'h2C;
         8'd41: c = 7'h2E;
         8'd42: c = 7'h20;
         default: c = CODE_NONE;
      endcase
      return c;
   endfunction

   // escape and arrow keys under fn
   function automatic logic [6:0] fn_code(input logic [7:0] id);
      logic [6:0] c;
      case (id)
         8'd0:  c = 7'h1B;
         8'd25: c = 7'h1E;
         8'd36: c = 7'h1F;
         8'd35: c = 7'h1D;
         8'd37: c = 7'h1C;
         default: c = CODE_NONE;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/kfkd_front.sv =====
// frame parser: takes serial bytes and pushes checked frames into the queue
module kfkd_front
   import kfkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  rx_byte,
   input  logic [31:0] now_ms,
   output logic        push,
   output frame_type   frame
);

   typedef enum logic [4:0] {
      PH_HEADER    = 5'b00001,
      PH_LENGTH    = 5'b00010,
      PH_KEY_ID    = 5'b00100,
      PH_KEY_STATE = 5'b01000,
      PH_CHECKSUM  = 5'b10000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] key_id_ff, key_id_in;
   logic [7:0] key_state_ff, key_state_in;
   logic [7:0] checksum;

   assign checksum = LEN_BYTE + key_id_ff + key_state_ff;

   always_comb begin
      phase_in     = phase_ff;
      key_id_in    = key_id_ff;
      key_state_in = key_state_ff;
      push         = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               phase_in = (rx_byte == HDR_BYTE) ? PH_LENGTH : PH_HEADER;
            end
            PH_LENGTH: begin
               phase_in = (rx_byte == LEN_BYTE) ? PH_KEY_ID : PH_HEADER;
            end
            PH_KEY_ID: begin
               key_id_in = rx_byte;
               phase_in  = PH_KEY_STATE;
            end
            PH_KEY_STATE: begin
               key_state_in = rx_byte;
               phase_in     = PH_CHECKSUM;
            end
            PH_CHECKSUM: begin
               phase_in = PH_HEADER;
               push     = (rx_byte == checksum);
            end
            default: begin
               phase_in = (rx_byte == HDR_BYTE) ? PH_LENGTH : PH_HEADER;
            end
         endcase
      end
   end

   always_comb begin
      frame.key_id  = key_id_ff;
      frame.pressed = (key_state_ff == PRESS_CODE);
      frame.now_ms  = now_ms;
      if (key_id_ff == KEY_FN) begin
         frame.kind = KIND_FN;
      end else if (key_id_ff == KEY_SYM) begin
         frame.kind = KIND_SYM;
      end else if (key_id_ff == KEY_AA) begin
         frame.kind = KIND_AA;
      end else begin
         frame.kind = KIND_KEY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         key_id_ff    <= 8'd0;
         key_state_ff <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         key_id_ff    <= key_id_in;
         key_state_ff <= key_state_in;
      end
   end

endmodule

// ===== hdl/kfkd_queue.sv =====
// short frame queue between the parser and the key handler
module kfkd_queue
   import kfkd_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_frame,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output frame_type head_frame
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   frame_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_frame = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/kfkd_back.sv =====
// key handler: modifier state, tap timing, table translation and result register
module kfkd_back
   import kfkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data,
   input  logic        head_valid,
   input  frame_type   head_frame,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_key_code
);

   logic [15:0] window_ff;
   logic        fn_held_ff, fn_held_in;
   logic        symbol_ff, symbol_in;
   logic        caps_ff, caps_in;
   logic        one_shot_ff, one_shot_in;
   logic [31:0] last_tap_ff, last_tap_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  rsp_code_ff;
   logic [31:0] gap;
   logic        in_window;
   logic        use_caps;
   logic [6:0]  lookup;
   logic [6:0]  code;

   assign pop          = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = rsp_code_ff;

   assign gap       = head_frame.now_ms - last_tap_ff;
   assign in_window = (gap <= {16'd0, window_ff});
   assign use_caps  = caps_ff || one_shot_ff;

   always_comb begin
      if (!head_frame.pressed) begin
         lookup = CODE_NONE;
      end else if (fn_held_ff) begin
         lookup = fn_code(head_frame.key_id);
      end else if (symbol_ff) begin
         lookup = sym_code(head_frame.key_id);
      end else if (use_caps) begin
         lookup = caps_code(head_frame.key_id);
      end else begin
         lookup = normal_code(head_frame.key_id);
      end
   end

   always_comb begin
      fn_held_in  = fn_held_ff;
      symbol_in   = symbol_ff;
      caps_in     = caps_ff;
      one_shot_in = one_shot_ff;
      last_tap_in = last_tap_ff;
      code        = CODE_NONE;
      if (pop) begin
         case (head_frame.kind)
            KIND_FN: begin
               fn_held_in = head_frame.pressed;
            end
            KIND_SYM: begin
               if (head_frame.pressed) begin
                  symbol_in = !symbol_ff;
                  if (!symbol_ff) begin
                     caps_in = 1'b0;
                  end
               end
            end
            KIND_AA: begin
               if (head_frame.pressed && !symbol_ff) begin
                  if (caps_ff) begin
                     caps_in     = 1'b0;
                     one_shot_in = 1'b0;
                     last_tap_in = '0;
                  end else if (one_shot_ff && in_window) begin
                     caps_in     = 1'b1;
                     one_shot_in = 1'b0;
                     last_tap_in = '0;
                  end else begin
                     one_shot_in = 1'b1;
                     last_tap_in = head_frame.now_ms;
                  end
               end
            end
            KIND_KEY: begin
               code = lookup;
               // one-shot shift is used up by a capital letter only
               if (!fn_held_ff && !symbol_ff && one_shot_ff &&
                   lookup >= CHAR_UPPER_A && lookup <= CHAR_UPPER_Z) begin
                  one_shot_in = 1'b0;
               end
            end
            default: begin
               code = CODE_NONE;
            end
         endcase
      end
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = (code != CODE_NONE);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && code != CODE_NONE) begin
         rsp_code_ff <= code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         fn_held_ff   <= 1'b0;
         symbol_ff    <= 1'b0;
         caps_ff      <= 1'b0;
         one_shot_ff  <= 1'b0;
         last_tap_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            window_ff <= csr_write_data;
         end
         fn_held_ff   <= fn_held_in;
         symbol_ff    <= symbol_in;
         caps_ff      <= caps_in;
         one_shot_ff  <= one_shot_in;
         last_tap_ff  <= last_tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/keyboard_frame_key_decoder_core.sv =====
// top level of the keyboard frame key decoder: parser, frame queue and key handler
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_rx_byte[7:0], req_now_ms[31:0]
//  rsp     | out       | rsp_valid/rsp_stall | rsp_key_code[6:0]
//  csr     | in        | csr_write_en        | csr_write_data[15:0] (tap window, ms)
//
//  one byte item per cycle while req_stall is low; after the checksum byte of its frame a
//  result passes through the frame queue and then the result register
//  synchronous reset clears parser, queue, modifier flags and sets the window to 400
//  req_stall rises while the frame queue is full; the queue fills only while
//  rsp_stall holds a result in the output register
module keyboard_frame_key_decoder_core
   import kfkd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_key_code,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);

   logic      req_accept;
   logic      front_push;
   frame_type front_frame;
   logic      q_full;
   logic      q_pop;
   logic      q_valid;
   frame_type q_frame;

   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   kfkd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_rx_byte),
      .now_ms  (req_now_ms),
      .push    (front_push),
      .frame   (front_frame)
   );

   kfkd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_frame (front_frame),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_frame (q_frame)
   );

   kfkd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .head_valid     (q_valid),
      .head_frame     (q_frame),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_key_code   (rsp_key_code)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !front_push)
      else $error("frame pushed into a full queue");

   a_push_fills_queue: assert property (@(posedge clock) disable iff (reset)
      front_push |=> q_valid)
      else $error("pushed frame missing from queue");

   a_no_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_key_code != CODE_NONE))
      else $error("zero key code offered as an item");
`endif

endmodule
